@@ design/tpm_pkg.sv @@
// tpm_pkg: shared types and constants for the tilt-to-pointer-motion block.
// Used by tpm_lane, tpm_out and tilt_to_pointer_motion. No dependencies.

package tpm_pkg;

   localparam int HISTORY_LEN_DEF = 10;
   localparam int SCALE_DIV_DEF   = 50;

   localparam int SAMPLE_W  = 16;
   localparam int MOVE_W    = 8;
   localparam int THRESH_W  = 15;
   localparam int SMOOTH_W  = 25;
   localparam int CSR_IDX_W = 1;

   localparam logic [THRESH_W-1:0] MOTION_THRESHOLD_RESET = 15'd25;
   localparam logic [THRESH_W-1:0] REST_THRESHOLD_RESET   = 15'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOTION_THRESHOLD = 1'b0,
      CSR_REST_THRESHOLD   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic shift1;
      logic shift2;
      logic commit;
   } lane_ctrl_type;

   typedef struct packed {
      logic signed [MOVE_W-1:0] move_x;
      logic signed [MOVE_W-1:0] move_y;
   } move_pair_type;

endpackage

@@ design/tilt_to_pointer_motion.sv @@
// Path: an accepted transaction passes lane stages 0 to 3, then enters the output queue, which raises rsp_valid.
// Throughput: one transaction per cycle; the four-stage lane pipeline and the
// two-entry output queue stall together when the queue is full.
// Reset clears averages, histories, held steps, pipeline and queue; thresholds
// return to 25 (motion) and 5 (rest).
// Depends on tpm_pkg, tpm_lane, tpm_out.

module tilt_to_pointer_motion #(
   parameter int HISTORY_LEN = tpm_pkg::HISTORY_LEN_DEF,
   parameter int SCALE_DIV   = tpm_pkg::SCALE_DIV_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [tpm_pkg::SAMPLE_W-1:0]       req_accel_x,
   input  logic signed [tpm_pkg::SAMPLE_W-1:0]       req_accel_y,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [tpm_pkg::MOVE_W-1:0]         rsp_move_x,
   output logic signed [tpm_pkg::MOVE_W-1:0]         rsp_move_y,
   input  logic                                      csr_wr_en,
   input  logic        [tpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic        [tpm_pkg::THRESH_W-1:0]       csr_wdata
);

   logic [tpm_pkg::THRESH_W-1:0] motion_thr_ff, rest_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_thr_ff <= tpm_pkg::MOTION_THRESHOLD_RESET;
         rest_thr_ff   <= tpm_pkg::REST_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (tpm_pkg::csr_index_type'(csr_index))
            tpm_pkg::CSR_MOTION_THRESHOLD: motion_thr_ff <= csr_wdata;
            tpm_pkg::CSR_REST_THRESHOLD:   rest_thr_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en, room;
   logic v1_ff, v2_ff, v3_ff;
   tpm_pkg::lane_ctrl_type ctrl;
   tpm_pkg::move_pair_type merged;

   assign en        = room;
   assign req_ready = en;

   always_comb begin
      ctrl.accept = req_valid && en;
      ctrl.shift1 = v1_ff && en;
      ctrl.shift2 = v2_ff && en;
      ctrl.commit = v3_ff && en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   tpm_lane #(
      .HISTORY_LEN (HISTORY_LEN),
      .SCALE_DIV   (SCALE_DIV),
      .NEGATE      (1'b1)
   ) u_lane_x (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .sample           (req_accel_x),
      .motion_threshold (motion_thr_ff),
      .rest_threshold   (rest_thr_ff),
      .held_next        (merged.move_x)
   );

   tpm_lane #(
      .HISTORY_LEN (HISTORY_LEN),
      .SCALE_DIV   (SCALE_DIV),
      .NEGATE      (1'b0)
   ) u_lane_y (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .sample           (req_accel_y),
      .motion_threshold (motion_thr_ff),
      .rest_threshold   (rest_thr_ff),
      .held_next        (merged.move_y)
   );

   tpm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (ctrl.commit),
      .push_data  (merged),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_move_x (rsp_move_x),
      .rsp_move_y (rsp_move_y)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> v1_ff)
      else $error("accepted transaction missing from pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !en |=> v3_ff)
      else $error("stalled result dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

@@ design/tpm_lane.sv @@
// tpm_lane: one axis of the motion pipeline (average, history, scale, hold).
// Depends on tpm_pkg. Two instances run side by side in the top level.

module tpm_lane #(
   parameter int HISTORY_LEN = tpm_pkg::HISTORY_LEN_DEF,
   parameter int SCALE_DIV   = tpm_pkg::SCALE_DIV_DEF,
   parameter bit NEGATE      = 1'b0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tpm_pkg::lane_ctrl_type                  ctrl,
   input  logic signed [tpm_pkg::SAMPLE_W-1:0]     sample,
   input  logic        [tpm_pkg::THRESH_W-1:0]     motion_threshold,
   input  logic        [tpm_pkg::THRESH_W-1:0]     rest_threshold,
   output logic signed [tpm_pkg::MOVE_W-1:0]       held_next
);

   // exact divide by SCALE_DIV for 16-bit magnitudes: q = (x * M) >> S
   localparam int DIV_SHIFT = 16 + $clog2(SCALE_DIV);
   localparam int DIV_MULT_INT = ((1 << DIV_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
   localparam int MULT_W = 18;
   localparam int PROD_W = 16 + MULT_W;
   localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_INT);

   // stage 0: running average
   logic                                 seeded_ff;
   logic signed [tpm_pkg::SMOOTH_W-1:0]  smooth_ff, smooth_in;
   logic signed [tpm_pkg::SMOOTH_W:0]    sum;

   always_comb begin
      sum = {{2{sample[15]}}, sample, 8'h00} + {smooth_ff[24], smooth_ff};
      smooth_in = seeded_ff ? sum[25:1] : {sample[15], sample, 8'h00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         smooth_ff <= '0;
      end else if (ctrl.accept) begin
         seeded_ff <= 1'b1;
         smooth_ff <= smooth_in;
      end
   end

   // stage 1: magnitude, integer part, motion compares
   logic        [23:0]                   mag_s;
   logic        [15:0]                   ip_mag;
   logic signed [tpm_pkg::SMOOTH_W-1:0]  lim_s;
   logic                                 above1, below1;

   always_comb begin
      mag_s  = smooth_ff[24] ? 24'(-smooth_ff) : smooth_ff[23:0];
      ip_mag = mag_s[23:8];
      lim_s  = {2'b00, motion_threshold, 8'h00};
      above1 = smooth_ff > lim_s;
      below1 = smooth_ff < -lim_s;
   end

   logic [15:0] hist_ff [HISTORY_LEN];
   logic [15:0] ipmag2_ff;
   logic        neg2_ff, above2_ff, below2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_LEN; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (ctrl.shift1) begin
         hist_ff[0] <= ip_mag;
         for (int k = 1; k < HISTORY_LEN; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift1) begin
         ipmag2_ff <= ip_mag;
         neg2_ff   <= smooth_ff[24];
         above2_ff <= above1;
         below2_ff <= below1;
      end
   end

   // stage 2: rest check over history, reciprocal multiply
   logic              at_rest;
   logic [PROD_W-1:0] prod;

   always_comb begin
      at_rest = 1'b1;
      for (int k = 0; k < HISTORY_LEN; k++) begin
         if (hist_ff[k] > {1'b0, rest_threshold}) begin
            at_rest = 1'b0;
         end
      end
      prod = PROD_W'(ipmag2_ff) * PROD_W'(DIV_MULT);
   end

   logic [15:0] q3_ff;
   logic        neg3_ff, above3_ff, below3_ff, rest3_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift2) begin
         q3_ff     <= 16'(prod >> DIV_SHIFT);
         neg3_ff   <= neg2_ff;
         above3_ff <= above2_ff;
         below3_ff <= below2_ff;
         rest3_ff  <= at_rest;
      end
   end

   // stage 3: hold update
   logic signed [tpm_pkg::MOVE_W-1:0] held_ff;
   logic signed [tpm_pkg::MOVE_W-1:0] val, h0, h1;
   logic        [8:0]                 mag_h;
   logic                              out_neg, grow_pos, grow_neg;

   always_comb begin
      out_neg  = neg3_ff ^ NEGATE;
      grow_pos = NEGATE ? below3_ff : above3_ff;
      grow_neg = NEGATE ? above3_ff : below3_ff;
      if (out_neg) begin
         val = (q3_ff > 16'd128) ? 8'sh80 : 8'(8'd0 - q3_ff[7:0]);
      end else begin
         val = (q3_ff > 16'd127) ? 8'sh7f : q3_ff[7:0];
      end
      h0 = rest3_ff ? '0 : held_ff;
      h1 = ((h0 == '0) && (above3_ff || below3_ff)) ? val : h0;
      mag_h = h1[7] ? 9'(9'd256 - {1'b0, h1}) : {1'b0, h1};
      held_next = h1;
      if (!h1[7] && (h1 != '0) && grow_pos && (q3_ff > {7'b0, mag_h})) begin
         held_next = val;
      end
      if (h1[7] && grow_neg && (q3_ff > {7'b0, mag_h})) begin
         held_next = val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (ctrl.commit) begin
         held_ff <= held_next;
      end
   end

   a_rest_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit && rest3_ff && !above3_ff && !below3_ff |=> held_ff == '0)
      else $error("held value not cleared at rest");

   a_hold_keeps_sign: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit && !rest3_ff && (held_ff != '0)
      |=> (held_ff != '0) && (held_ff[7] == $past(held_ff[7])))
      else $error("held value changed direction without rest");

   a_seed: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && !seeded_ff |=> smooth_ff == $past({sample[15], sample, 8'h00}))
      else $error("first sample did not seed the average");

endmodule

@@ design/tpm_out.sv @@
// tpm_out: merge of the two lane results into a two-entry output queue.
// Depends on tpm_pkg. Drives the rsp_ channel of the top level.

module tpm_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  tpm_pkg::move_pair_type               push_data,
   output logic                                 room,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tpm_pkg::MOVE_W-1:0]    rsp_move_x,
   output logic signed [tpm_pkg::MOVE_W-1:0]    rsp_move_y
);

   tpm_pkg::move_pair_type entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       pop;

   assign room       = (cnt_ff != 2'd2);
   assign rsp_valid  = (cnt_ff != 2'd0);
   assign pop        = rsp_valid && rsp_ready;
   assign rsp_move_x = entry_ff[rd_ff].move_x;
   assign rsp_move_y = entry_ff[rd_ff].move_y;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
